/* sv/pps_pkg.sv */
// Shared types and constants of the preemptive priority scheduler.
package pps_pkg;

  localparam int unsigned SLOTS_DEF = 16;

  localparam int unsigned ID_W    = 8;
  localparam int unsigned BURST_W = 16;
  localparam int unsigned PRIO_W  = 8;
  localparam int unsigned TIME_W  = 32;

  localparam int unsigned IN_DATA_W  = 32;
  localparam int unsigned OUT_DATA_W = 48;

  typedef enum logic [1:0] {
    STAT_OK   = 2'd0,
    STAT_FULL = 2'd1,
    STAT_ZERO = 2'd2,
    STAT_IDLE = 2'd3
  } status_t;

  typedef enum logic {
    MODE_ADMIT = 1'b0,
    MODE_TICK  = 1'b1
  } mode_t;

  typedef struct packed {
    logic [ID_W-1:0]    id;
    logic [BURST_W-1:0] remaining;
    logic [BURST_W-1:0] burst;
    logic [PRIO_W-1:0]  prio;
    logic [TIME_W-1:0]  arrival;
  } slot_entry_t;

endpackage

/* sv/pps_slot_mem.sv */
// Slot table memory: one write port and one registered read port.
module pps_slot_mem #(
  parameter int unsigned SLOTS = pps_pkg::SLOTS_DEF,
  parameter int unsigned IW    = $clog2(SLOTS)
) (
  input  logic                clk,
  input  logic                wr_en,
  input  logic [IW-1:0]       wr_addr,
  input  pps_pkg::slot_entry_t wr_data,
  input  logic [IW-1:0]       rd_addr,
  output pps_pkg::slot_entry_t rd_data
);

  pps_pkg::slot_entry_t mem [SLOTS];
  pps_pkg::slot_entry_t rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    rd_data_r <= mem[rd_addr];
  end

  assign rd_data = rd_data_r;

endmodule

/* sv/preemptive_priority_scheduler.sv */
// Top level of the preemptive priority scheduler: sequencer, compare unit and slot flags.
// Admit: one slot flag checked per cycle.
// Tick: a one-read-per-cycle scan of the slot memory through a single shared compare unit,
// then an update step, plus a difference and a wait step when the process finishes.
// One item is in work at a time; a new item is taken once the result is in the output register.
// Synchronous active-low reset empties the table and zeroes the time; memory contents stay.
module preemptive_priority_scheduler #(
  parameter int unsigned SLOTS = pps_pkg::SLOTS_DEF
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_tvalid,
  output logic                            in_tready,
  // [7:0] proc_id, [23:8] burst_len, [31:24] prio_level
  input  logic [pps_pkg::IN_DATA_W-1:0]   in_tdata,
  // [0] mode
  input  logic                            in_tuser,
  output logic                            out_tvalid,
  input  logic                            out_tready,
  // [7:0] running_id, [8] finished, [40:9] wait_time, [47:41] zero
  output logic [pps_pkg::OUT_DATA_W-1:0]  out_tdata,
  // [1:0] status
  output logic [1:0]                      out_tuser
);

  localparam int unsigned IW = $clog2(SLOTS);
  localparam int unsigned CW = $clog2(SLOTS + 1);

  typedef enum logic [6:0] {
    S_IDLE  = 7'b0000001,
    S_ASCAN = 7'b0000010,
    S_TSCAN = 7'b0000100,
    S_TUPD  = 7'b0001000,
    S_TDIFF = 7'b0010000,
    S_TWAIT = 7'b0100000,
    S_EMIT  = 7'b1000000
  } state_t;

  state_t state_r, state_nxt;

  logic [SLOTS-1:0] valid_r, valid_nxt;
  logic [CW-1:0]    cnt_r, cnt_nxt;
  logic [pps_pkg::TIME_W-1:0] now_r, now_nxt;

  logic [pps_pkg::ID_W-1:0]    inp_id_r, inp_id_nxt;
  logic [pps_pkg::BURST_W-1:0] inp_burst_r, inp_burst_nxt;
  logic [pps_pkg::PRIO_W-1:0]  inp_prio_r, inp_prio_nxt;

  logic           pend_r, pend_nxt;
  logic           pend_vld_r, pend_vld_nxt;
  logic [IW-1:0]  pend_idx_r, pend_idx_nxt;

  logic                 found_r, found_nxt;
  logic [IW-1:0]        best_idx_r, best_idx_nxt;
  pps_pkg::slot_entry_t best_r, best_nxt;
  logic [pps_pkg::TIME_W-1:0] diff_r, diff_nxt;

  pps_pkg::status_t            res_status_r, res_status_nxt;
  logic [pps_pkg::ID_W-1:0]    res_id_r, res_id_nxt;
  logic                        res_fin_r, res_fin_nxt;
  logic [pps_pkg::TIME_W-1:0]  res_wait_r, res_wait_nxt;

  logic                        out_valid_r, out_valid_nxt;
  pps_pkg::status_t            out_status_r, out_status_nxt;
  logic [pps_pkg::ID_W-1:0]    out_id_r, out_id_nxt;
  logic                        out_fin_r, out_fin_nxt;
  logic [pps_pkg::TIME_W-1:0]  out_wait_r, out_wait_nxt;

  logic                 wr_en;
  logic [IW-1:0]        wr_addr;
  pps_pkg::slot_entry_t wr_data;
  logic [IW-1:0]        rd_addr;
  pps_pkg::slot_entry_t rd_data;

  logic                 in_acc;
  logic                 better;
  logic [IW-1:0]        cnt_idx;
  logic [pps_pkg::BURST_W-1:0] in_burst;

  assign cnt_idx   = cnt_r[IW-1:0];
  assign rd_addr   = cnt_idx;
  assign in_tready = (state_r == S_IDLE);
  assign in_acc    = in_tvalid && in_tready;
  assign in_burst  = in_tdata[23:8];

  pps_slot_mem #(
    .SLOTS (SLOTS),
    .IW    (IW)
  ) u_slot_mem (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  // Shared compare unit: lower priority number wins, then smaller remaining burst.
  // A strict compare keeps the lower slot on a full tie since slots arrive in order.
  always_comb begin
    better = !found_r
          || (rd_data.prio < best_r.prio)
          || ((rd_data.prio == best_r.prio) && (rd_data.remaining < best_r.remaining));
  end

  always_comb begin
    state_nxt      = state_r;
    valid_nxt      = valid_r;
    cnt_nxt        = cnt_r;
    now_nxt        = now_r;
    inp_id_nxt     = inp_id_r;
    inp_burst_nxt  = inp_burst_r;
    inp_prio_nxt   = inp_prio_r;
    pend_nxt       = 1'b0;
    pend_vld_nxt   = 1'b0;
    pend_idx_nxt   = pend_idx_r;
    found_nxt      = found_r;
    best_idx_nxt   = best_idx_r;
    best_nxt       = best_r;
    diff_nxt       = diff_r;
    res_status_nxt = res_status_r;
    res_id_nxt     = res_id_r;
    res_fin_nxt    = res_fin_r;
    res_wait_nxt   = res_wait_r;
    out_valid_nxt  = out_valid_r && !out_tready;
    out_status_nxt = out_status_r;
    out_id_nxt     = out_id_r;
    out_fin_nxt    = out_fin_r;
    out_wait_nxt   = out_wait_r;
    wr_en          = 1'b0;
    wr_addr        = cnt_idx;
    wr_data        = '0;

    unique case (state_r)
      S_IDLE: begin
        if (in_acc) begin
          inp_id_nxt    = in_tdata[7:0];
          inp_burst_nxt = in_burst;
          inp_prio_nxt  = in_tdata[31:24];
          cnt_nxt       = '0;
          found_nxt     = 1'b0;
          res_id_nxt    = '0;
          res_fin_nxt   = 1'b0;
          res_wait_nxt  = '0;
          if (in_tuser == pps_pkg::MODE_TICK) begin
            state_nxt = S_TSCAN;
          end else if (in_burst == '0) begin
            res_status_nxt = pps_pkg::STAT_ZERO;
            state_nxt      = S_EMIT;
          end else begin
            state_nxt = S_ASCAN;
          end
        end
      end

      S_ASCAN: begin
        if (!valid_r[cnt_idx]) begin
          wr_en             = 1'b1;
          wr_addr           = cnt_idx;
          wr_data.id        = inp_id_r;
          wr_data.remaining = inp_burst_r;
          wr_data.burst     = inp_burst_r;
          wr_data.prio      = inp_prio_r;
          wr_data.arrival   = now_r;
          valid_nxt[cnt_idx] = 1'b1;
          res_status_nxt    = pps_pkg::STAT_OK;
          state_nxt         = S_EMIT;
        end else if (cnt_r == CW'(SLOTS - 1)) begin
          res_status_nxt = pps_pkg::STAT_FULL;
          state_nxt      = S_EMIT;
        end else begin
          cnt_nxt = cnt_r + 1'b1;
        end
      end

      S_TSCAN: begin
        // Read data arrives in the cycle after its address; the pend stage tracks it.
        if (cnt_r != CW'(SLOTS)) begin
          pend_nxt     = 1'b1;
          pend_vld_nxt = valid_r[cnt_idx];
          pend_idx_nxt = cnt_idx;
          cnt_nxt      = cnt_r + 1'b1;
        end else begin
          state_nxt = S_TUPD;
        end
        if (pend_r && pend_vld_r && better) begin
          found_nxt    = 1'b1;
          best_idx_nxt = pend_idx_r;
          best_nxt     = rd_data;
        end
      end

      S_TUPD: begin
        now_nxt = now_r + 1'b1;
        if (!found_r) begin
          res_status_nxt = pps_pkg::STAT_IDLE;
          state_nxt      = S_EMIT;
        end else begin
          wr_en             = 1'b1;
          wr_addr           = best_idx_r;
          wr_data           = best_r;
          wr_data.remaining = best_r.remaining - 1'b1;
          res_status_nxt    = pps_pkg::STAT_OK;
          res_id_nxt        = best_r.id;
          if (best_r.remaining == pps_pkg::BURST_W'(1)) begin
            valid_nxt[best_idx_r] = 1'b0;
            state_nxt             = S_TDIFF;
          end else begin
            state_nxt = S_EMIT;
          end
        end
      end

      S_TDIFF: begin
        diff_nxt  = now_r - best_r.arrival;
        state_nxt = S_TWAIT;
      end

      S_TWAIT: begin
        res_fin_nxt  = 1'b1;
        res_wait_nxt = diff_r - {{(pps_pkg::TIME_W - pps_pkg::BURST_W){1'b0}}, best_r.burst};
        state_nxt    = S_EMIT;
      end

      S_EMIT: begin
        if (!out_valid_r || out_tready) begin
          out_valid_nxt  = 1'b1;
          out_status_nxt = res_status_r;
          out_id_nxt     = res_id_r;
          out_fin_nxt    = res_fin_r;
          out_wait_nxt   = res_wait_r;
          state_nxt      = S_IDLE;
        end
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      valid_r     <= '0;
      now_r       <= '0;
      cnt_r       <= '0;
      pend_r      <= 1'b0;
      pend_vld_r  <= 1'b0;
      found_r     <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      valid_r     <= valid_nxt;
      now_r       <= now_nxt;
      cnt_r       <= cnt_nxt;
      pend_r      <= pend_nxt;
      pend_vld_r  <= pend_vld_nxt;
      found_r     <= found_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    inp_id_r     <= inp_id_nxt;
    inp_burst_r  <= inp_burst_nxt;
    inp_prio_r   <= inp_prio_nxt;
    pend_idx_r   <= pend_idx_nxt;
    best_idx_r   <= best_idx_nxt;
    best_r       <= best_nxt;
    diff_r       <= diff_nxt;
    res_status_r <= res_status_nxt;
    res_id_r     <= res_id_nxt;
    res_fin_r    <= res_fin_nxt;
    res_wait_r   <= res_wait_nxt;
    out_status_r <= out_status_nxt;
    out_id_r     <= out_id_nxt;
    out_fin_r    <= out_fin_nxt;
    out_wait_r   <= out_wait_nxt;
  end

  assign out_tvalid = out_valid_r;
  assign out_tuser  = out_status_r;
  assign out_tdata  = {{(pps_pkg::OUT_DATA_W - pps_pkg::TIME_W - 1 - pps_pkg::ID_W){1'b0}},
                       out_wait_r, out_fin_r, out_id_r};

  // A finished process is only ever reported with the ran status.
  a_fin_ok: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_fin_r |-> out_status_r == pps_pkg::STAT_OK)
    else $error("finished result without ran status");

  // The slot table is written only while admitting or updating after a scan.
  a_wr_state: assert property (@(posedge clk) disable iff (!rst_n)
    wr_en |-> (state_r == S_ASCAN) || (state_r == S_TUPD))
    else $error("slot write outside admit or update");

  // Time moves only in the update step of a tick.
  a_now_hold: assert property (@(posedge clk) disable iff (!rst_n)
    state_r != S_TUPD |=> $stable(now_r))
    else $error("time changed outside a tick update");

  // At most one slot is taken or freed per cycle.
  a_one_slot: assert property (@(posedge clk) disable iff (!rst_n)
    1'b1 |=> ($countones(valid_r) == $countones($past(valid_r)))
          || ($countones(valid_r) == $countones($past(valid_r)) + 1)
          || ($countones(valid_r) + 1 == $countones($past(valid_r))))
    else $error("more than one slot changed in a cycle");

  // A scan result is only consumed with a slot flagged as occupied.
  a_found_valid: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_TUPD) && found_r |-> valid_r[best_idx_r])
    else $error("selected slot is not occupied");

endmodule

/* verif/preemptive_priority_scheduler_tb.sv */
// Self-checking testbench for the preemptive priority scheduler with a scheduling predictor.
`timescale 1ns / 1ps

module preemptive_priority_scheduler_tb;

  localparam int NUM_SLOTS    = pps_pkg::SLOTS_DEF;
  localparam int RANDOM_ITEMS = 1400;

  localparam int unsigned ID_W       = pps_pkg::ID_W;
  localparam int unsigned BURST_W    = pps_pkg::BURST_W;
  localparam int unsigned PRIO_W     = pps_pkg::PRIO_W;
  localparam int unsigned TIME_W     = pps_pkg::TIME_W;
  localparam int unsigned IN_DATA_W  = pps_pkg::IN_DATA_W;
  localparam int unsigned OUT_DATA_W = pps_pkg::OUT_DATA_W;

  typedef struct {
    pps_pkg::mode_t       mode;
    logic [ID_W-1:0]      pid;
    logic [BURST_W-1:0]   blen;
    logic [PRIO_W-1:0]    plev;
  } job_t;

  typedef struct packed {
    pps_pkg::status_t     status;
    logic [ID_W-1:0]      run_id;
    logic                 done;
    logic [TIME_W-1:0]    wait_cycles;
    logic                 ran;
  } sched_result_t;

  logic                  clk = 1'b0;
  logic                  rst_n = 1'b0;
  logic                  in_tvalid = 1'b0;
  logic                  in_tready;
  logic [IN_DATA_W-1:0]  in_tdata = '0;
  logic                  in_tuser = 1'b0;
  logic                  out_tvalid;
  logic                  out_tready = 1'b0;
  logic [OUT_DATA_W-1:0] out_tdata;
  logic [1:0]            out_tuser;

  // Shadow copy of the process table and the clock of the scheduler.
  logic                  tbl_valid [NUM_SLOTS];
  logic [ID_W-1:0]       tbl_id    [NUM_SLOTS];
  logic [BURST_W-1:0]    tbl_left  [NUM_SLOTS];
  logic [BURST_W-1:0]    tbl_burst [NUM_SLOTS];
  logic [PRIO_W-1:0]     tbl_prio  [NUM_SLOTS];
  logic [TIME_W-1:0]     tbl_arr   [NUM_SLOTS];
  logic [TIME_W-1:0]     sched_now = '0;

  job_t          stim_q[$];
  sched_result_t result_q[$];

  int errors = 0;
  int n_accepted = 0;
  int n_results = 0;
  int n_admitted = 0;
  int n_finished = 0;
  int n_full = 0;
  int n_zero = 0;
  int n_idle = 0;
  int n_ran = 0;

  preemptive_priority_scheduler uut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser)
  );

  always #5 clk = ~clk;

  initial begin
    for (int s = 0; s < NUM_SLOTS; s++) begin
      tbl_valid[s] = 1'b0;
    end
  end

  // Applies one item to the shadow table and returns the result the block must give.
  function automatic sched_result_t apply_item(pps_pkg::mode_t m, logic [ID_W-1:0] pid,
                                               logic [BURST_W-1:0] blen,
                                               logic [PRIO_W-1:0] plev);
    sched_result_t r;
    int            pick;
    r.status      = pps_pkg::STAT_OK;
    r.run_id      = '0;
    r.done        = 1'b0;
    r.wait_cycles = '0;
    r.ran         = 1'b0;
    pick          = -1;
    if (m == pps_pkg::MODE_ADMIT) begin
      if (blen == '0) begin
        r.status = pps_pkg::STAT_ZERO;
      end else begin
        for (int s = NUM_SLOTS - 1; s >= 0; s--) begin
          if (!tbl_valid[s]) pick = s;
        end
        if (pick < 0) begin
          r.status = pps_pkg::STAT_FULL;
        end else begin
          tbl_valid[pick] = 1'b1;
          tbl_id[pick]    = pid;
          tbl_left[pick]  = blen;
          tbl_burst[pick] = blen;
          tbl_prio[pick]  = plev;
          tbl_arr[pick]   = sched_now;
        end
      end
    end else begin
      // Strict comparisons keep the lowest slot on a full tie.
      for (int s = 0; s < NUM_SLOTS; s++) begin
        if (tbl_valid[s] && (pick < 0 || tbl_prio[s] < tbl_prio[pick] ||
            (tbl_prio[s] == tbl_prio[pick] && tbl_left[s] < tbl_left[pick]))) begin
          pick = s;
        end
      end
      sched_now = sched_now + 1'b1;
      if (pick < 0) begin
        r.status = pps_pkg::STAT_IDLE;
      end else begin
        tbl_left[pick] = tbl_left[pick] - 1'b1;
        r.run_id       = tbl_id[pick];
        r.ran          = 1'b1;
        if (tbl_left[pick] == '0) begin
          r.done          = 1'b1;
          r.wait_cycles   = sched_now - tbl_arr[pick] - TIME_W'(tbl_burst[pick]);
          tbl_valid[pick] = 1'b0;
        end
      end
    end
    return r;
  endfunction

  task automatic push_admit(logic [ID_W-1:0] pid, logic [BURST_W-1:0] blen,
                            logic [PRIO_W-1:0] plev);
    job_t j;
    j.mode = pps_pkg::MODE_ADMIT;
    j.pid  = pid;
    j.blen = blen;
    j.plev = plev;
    stim_q = {stim_q, j};
  endtask

  task automatic push_tick();
    job_t j;
    j.mode = pps_pkg::MODE_TICK;
    j.pid  = ID_W'($urandom_range(0, 255));
    j.blen = BURST_W'($urandom_range(0, 65535));
    j.plev = PRIO_W'($urandom_range(0, 255));
    stim_q = {stim_q, j};
  endtask

  // Mostly short bursts with crowded priorities; rare long bursts sit at the bottom priority.
  task automatic push_random_admit();
    logic [BURST_W-1:0] blen;
    logic [PRIO_W-1:0]  plev;
    int                 r;
    r = $urandom_range(0, 99);
    if (r < 5) begin
      blen = '0;
    end else if (r < 6) begin
      blen = BURST_W'($urandom_range(256, 65535));
    end else begin
      blen = BURST_W'($urandom_range(1, 3));
    end
    if (blen > 255) begin
      plev = 8'hFF;
    end else if ($urandom_range(0, 1) == 0) begin
      plev = PRIO_W'($urandom_range(0, 3));
    end else begin
      plev = PRIO_W'($urandom_range(0, 254));
    end
    push_admit(ID_W'($urandom_range(0, 255)), blen, plev);
  endtask

  task automatic check_field(string name, logic [TIME_W-1:0] want, logic [TIME_W-1:0] got);
    if (got !== want) begin
      errors++;
      $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
    end
  endtask

  // Feeds queued items to the block, with random gaps outside the calm window.
  always @(posedge clk) begin
    job_t          nxt;
    logic          load;
    sched_result_t pred;
    if (!rst_n) begin
      in_tvalid <= 1'b0;
    end else begin
      if (in_tvalid && in_tready) begin
        pred = apply_item(pps_pkg::mode_t'(in_tuser), in_tdata[7:0], in_tdata[23:8],
                          in_tdata[31:24]);
        result_q = {result_q, pred};
        n_accepted++;
      end
      if (!in_tvalid || in_tready) begin
        load = stim_q.size() != 0 &&
               ((n_accepted >= 500 && n_accepted < 700) || $urandom_range(0, 99) >= 37);
        if (load) begin
          nxt = stim_q.pop_front();
          in_tdata <= {nxt.plev, nxt.blen, nxt.pid};
          in_tuser <= nxt.mode;
        end
        in_tvalid <= load;
      end
    end
  end

  // Checks every result item against the oldest prediction and drives back-pressure.
  always @(posedge clk) begin
    sched_result_t want;
    if (!rst_n) begin
      out_tready <= 1'b0;
    end else begin
      if (out_tvalid && out_tready) begin
        n_results++;
        if (result_q.size() == 0) begin
          errors++;
          $display("%0t: result item with nothing expected, actual status %0d data %0h",
                   $time, out_tuser, out_tdata);
        end else begin
          want = result_q.pop_front();
          check_field("status", TIME_W'(want.status), TIME_W'(out_tuser));
          check_field("running_id", TIME_W'(want.run_id), TIME_W'(out_tdata[7:0]));
          check_field("finished", TIME_W'(want.done), TIME_W'(out_tdata[8]));
          check_field("wait_time", want.wait_cycles, out_tdata[40:9]);
          case (want.status)
            pps_pkg::STAT_FULL: n_full++;
            pps_pkg::STAT_ZERO: n_zero++;
            pps_pkg::STAT_IDLE: n_idle++;
            default: begin
              if (want.ran) begin
                n_ran++;
              end else begin
                n_admitted++;
              end
            end
          endcase
          if (want.done) n_finished++;
        end
      end
      out_tready <= (n_results >= 500 && n_results < 700) || $urandom_range(0, 99) >= 37;
    end
  end

  initial begin
    int r;
    int run_len;
    // Idle tick on an empty table, then a zero burst.
    push_tick();
    push_admit(8'hFF, 16'h0000, 8'hFF);
    // A maximal burst at the weakest priority stays resident for the whole run.
    push_admit(8'hFF, 16'hFFFF, 8'hFF);
    push_admit(8'h00, 16'h0001, 8'h00);
    push_tick();
    // Duplicate ids and ties on priority, then on remaining burst.
    push_admit(8'h07, 16'h0003, 8'h05);
    push_admit(8'h07, 16'h0002, 8'h05);
    push_admit(8'h09, 16'h0002, 8'h05);
    for (int k = 0; k < 12; k++) begin
      push_admit(ID_W'(8'h10 + k), BURST_W'(k % 3 + 1), PRIO_W'(k * 21));
    end
    // Table is full here; the zero-burst check must still win.
    push_admit(8'hAA, 16'h5555, 8'h55);
    push_admit(8'h55, 16'h0000, 8'hAA);
    push_tick();
    push_tick();
    push_tick();

    while (stim_q.size() < RANDOM_ITEMS + 25) begin
      r = $urandom_range(0, 99);
      if (r < 1) begin
        run_len = $urandom_range(8, 18);
        for (int k = 0; k < run_len; k++) push_random_admit();
      end else if (r < 80) begin
        push_tick();
      end else begin
        push_random_admit();
      end
    end

    repeat (2) @(posedge clk);
    rst_n <= 1'b1;

    while (stim_q.size() != 0 || in_tvalid) @(negedge clk);
    while (result_q.size() != 0) @(negedge clk);
    repeat (30) @(posedge clk);

    $display("Ran %0d items: %0d admits, %0d ticks that ran a process, %0d completions.",
             n_accepted, n_admitted, n_ran, n_finished);
    $display("Rejected %0d on a full table and %0d for zero burst; %0d idle ticks.",
             n_full, n_zero, n_idle);
    if (errors == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

  initial begin
    #5_000_000;
    $display("Timed out with %0d items accepted and %0d results seen.", n_accepted, n_results);
    $display("status: fail");
    $finish;
  end

endmodule
